// File: rtl/ecb_pkg.sv
// types and constants shared by the serial command bridge
package ecb_pkg;

    // host command bytes
    localparam logic [7:0] OP_WBYTE     = 8'h01;
    localparam logic [7:0] OP_WSTREAM   = 8'h02;
    localparam logic [7:0] OP_RBYTE     = 8'h03;
    localparam logic [7:0] OP_RSTREAM   = 8'h04;
    localparam logic [7:0] OP_HANDSHAKE = 8'hAA;
    localparam logic [7:0] OP_ESCAPE    = 8'hFF;

    // reply bytes
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] NAK_BYTE = 8'h15;

    // input kinds carried on tuser
    localparam logic KIND_HOST = 1'b0;
    localparam logic KIND_MEM  = 1'b1;

    localparam int MEM_ADDR_W = 15;
    localparam int TDATA_W    = 40;

    // decoded command, stored after the command byte
    typedef enum logic [1:0] {
        CMD_WBYTE   = 2'd0,
        CMD_WSTREAM = 2'd1,
        CMD_RBYTE   = 2'd2,
        CMD_RSTREAM = 2'd3
    } cmd_t;

    // one result beat before packing
    typedef struct packed {
        logic                  send_valid;
        logic [7:0]            send_byte;
        logic                  write_valid;
        logic                  read_valid;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic [7:0]            mem_data;
        logic                  busy_res;
        logic                  last;
    } res_t;

endpackage

// File: rtl/ecb_page_ram.sv
// page buffer memory: one write port, one registered read port
module ecb_page_ram
    import ecb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ecb_out_reg.sv
// output register for result beats, packs the result into tdata
module ecb_out_reg
    import ecb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  res_t               res,
    output logic               space,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    logic valid_reg;
    res_t res_reg;

    // slot is free when empty or being drained this cycle
    assign space = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (space && load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {5'b0, res_reg.busy_res, res_reg.mem_data, res_reg.mem_addr,
                       res_reg.read_valid, res_reg.write_valid, res_reg.send_byte,
                       res_reg.send_valid};

endmodule

// File: rtl/eeprom_serial_command_bridge.sv
// top level of the serial command bridge: command decoder and page flush sequencer
//
//  channel | dir | beat contents
//  s_      | in  | tdata[7:0] value; tuser operation (0 host byte, 1 memory read data)
//  m_      | out | tdata: send_valid, send_byte, write_valid, read_valid, mem_addr,
//          |     |   mem_data, busy_res, zero pad; tlast marks the last result of an input
//
//  an input beat is registered into the output slot at the edge that accepts it, unless it starts a flush
//  a read-stream data beat is followed by the follow-up read request from C_RDREQ
//  a page flush reads each buffered byte from the page ram (C_FRD), then emits it (C_FEMIT);
//  no input is taken until the flush completes
//  output stalls hold the sequencer; reset clears all control state, the page ram is not cleared
module eeprom_serial_command_bridge
    import ecb_pkg::*;
#(
    parameter int PAGE_BYTES = 64,
    parameter int ADDR_WIDTH = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // value
    input  logic               s_tuser,   // operation
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // send_valid, send_byte, write_valid,
                                          // read_valid, mem_addr, mem_data, busy_res
    output logic               m_tlast
);

    localparam int IDX_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int FILL_W = $clog2(PAGE_BYTES + 1);
    localparam logic [15:0] ADDR_MASK = 16'((32'h1 << ADDR_WIDTH) - 32'h1);

    // command phase
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_ADDR_H = 6'b000010,
        PH_ADDR_L = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_READ   = 6'b010000,
        PH_STREAM = 6'b100000
    } phase_t;

    // result sequencer
    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_RDREQ = 4'b0010,
        C_FRD   = 4'b0100,
        C_FEMIT = 4'b1000
    } ctl_t;

    phase_t             phase_reg, phase_next;
    ctl_t               ctl_reg, ctl_next;
    cmd_t               cmd_reg, cmd_next;
    logic [15:0]        addr_reg, addr_next;
    logic [15:0]        start_reg, start_next;
    logic               start_valid_reg, start_valid_next;
    logic [15:0]        cursor_reg, cursor_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               esc_reg, esc_next;
    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [IDX_W-1:0]   flast_reg, flast_next;

    logic               accept;
    logic               out_space;
    logic               load;
    res_t               res;
    logic               ram_we;
    logic [7:0]         ram_rdata;
    logic [15:0]        addr_full;
    logic               fire_ack;

    function automatic logic [MEM_ADDR_W-1:0] addr_out(input logic [15:0] a);
        return MEM_ADDR_W'(a & ADDR_MASK);
    endfunction

    assign s_tready  = (ctl_reg == C_IDLE) && out_space;
    assign accept    = s_tvalid && s_tready;
    assign addr_full = {addr_reg[15:8], s_tdata};
    assign fire_ack  = (fidx_reg == flast_reg);

    // decode and sequencing
    always_comb
    begin
        phase_next       = phase_reg;
        ctl_next         = ctl_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        start_next       = start_reg;
        start_valid_next = start_valid_reg;
        cursor_next      = cursor_reg;
        fill_next        = fill_reg;
        esc_next         = esc_reg;
        busy_next        = busy_reg;
        fidx_next        = fidx_reg;
        flast_next       = flast_reg;
        load             = 1'b0;
        ram_we           = 1'b0;
        res              = '0;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    load     = 1'b1;
                    res.last = 1'b1;
                    if (s_tuser == KIND_MEM)
                    begin
                        if (phase_reg == PH_READ)
                        begin
                            res.send_valid = 1'b1;
                            res.send_byte  = s_tdata;
                            phase_next     = PH_IDLE;
                            busy_next      = 1'b0;
                        end
                        else if (phase_reg == PH_STREAM)
                        begin
                            res.send_valid = 1'b1;
                            res.send_byte  = s_tdata;
                            if (cursor_reg == addr_reg)
                            begin
                                start_valid_next = 1'b0;
                                phase_next       = PH_IDLE;
                                busy_next        = 1'b0;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + 16'd1;
                                res.last    = 1'b0;
                                ctl_next    = C_RDREQ;
                            end
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_IDLE:
                            begin
                                if (s_tdata == OP_WBYTE || s_tdata == OP_WSTREAM ||
                                    s_tdata == OP_RBYTE || s_tdata == OP_RSTREAM)
                                begin
                                    cmd_next   = cmd_t'(s_tdata[1:0] - 2'd1);
                                    phase_next = PH_ADDR_H;
                                    busy_next  = 1'b1;
                                end
                                else if (s_tdata == OP_HANDSHAKE || s_tdata == OP_ESCAPE)
                                begin
                                    res.send_valid = 1'b1;
                                    res.send_byte  = ACK_BYTE;
                                end
                                else
                                begin
                                    res.send_valid = 1'b1;
                                    res.send_byte  = NAK_BYTE;
                                end
                            end
                            PH_ADDR_H:
                            begin
                                addr_next  = {s_tdata, 8'h00};
                                phase_next = PH_ADDR_L;
                            end
                            PH_ADDR_L:
                            begin
                                addr_next = addr_full;
                                unique case (cmd_reg)
                                    CMD_WBYTE, CMD_WSTREAM:
                                    begin
                                        fill_next  = '0;
                                        esc_next   = 1'b0;
                                        phase_next = PH_DATA;
                                    end
                                    CMD_RBYTE:
                                    begin
                                        res.read_valid = 1'b1;
                                        res.mem_addr   = addr_out(addr_full);
                                        phase_next     = PH_READ;
                                    end
                                    default:
                                    begin
                                        if (!start_valid_reg)
                                        begin
                                            start_next       = addr_full;
                                            start_valid_next = 1'b1;
                                            phase_next       = PH_ADDR_H;
                                        end
                                        else
                                        begin
                                            start_valid_next = 1'b0;
                                            if (addr_full < start_reg)
                                            begin
                                                phase_next = PH_IDLE;
                                                busy_next  = 1'b0;
                                            end
                                            else
                                            begin
                                                cursor_next    = start_reg;
                                                res.read_valid = 1'b1;
                                                res.mem_addr   = addr_out(start_reg);
                                                phase_next     = PH_STREAM;
                                            end
                                        end
                                    end
                                endcase
                            end
                            PH_DATA:
                            begin
                                if (cmd_reg == CMD_WBYTE)
                                begin
                                    res.send_valid  = 1'b1;
                                    res.send_byte   = ACK_BYTE;
                                    res.write_valid = 1'b1;
                                    res.mem_addr    = addr_out(addr_reg);
                                    res.mem_data    = s_tdata;
                                    phase_next      = PH_IDLE;
                                    busy_next       = 1'b0;
                                end
                                else if (cmd_reg == CMD_WSTREAM)
                                begin
                                    if (esc_reg && s_tdata != OP_ESCAPE)
                                    begin
                                        // end of stream: flush the page
                                        esc_next   = 1'b0;
                                        fill_next  = '0;
                                        phase_next = PH_IDLE;
                                        busy_next  = 1'b0;
                                        if (fill_reg == '0)
                                        begin
                                            res.send_valid = 1'b1;
                                            res.send_byte  = ACK_BYTE;
                                        end
                                        else
                                        begin
                                            load       = 1'b0;
                                            fidx_next  = '0;
                                            flast_next = IDX_W'(fill_reg - FILL_W'(1));
                                            ctl_next   = C_FRD;
                                        end
                                    end
                                    else if (!esc_reg && s_tdata == OP_ESCAPE)
                                    begin
                                        esc_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // plain byte or escaped literal
                                        esc_next = 1'b0;
                                        if (fill_reg < FILL_W'(PAGE_BYTES))
                                        begin
                                            ram_we    = 1'b1;
                                            fill_next = fill_reg + FILL_W'(1);
                                        end
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    busy_next  = 1'b0;
                                end
                            end
                            PH_READ, PH_STREAM:
                            begin
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                busy_next  = 1'b0;
                            end
                        endcase
                    end
                end
            end
            C_RDREQ:
            begin
                if (out_space)
                begin
                    load           = 1'b1;
                    res.read_valid = 1'b1;
                    res.mem_addr   = addr_out(cursor_reg);
                    res.last       = 1'b1;
                    ctl_next       = C_IDLE;
                end
            end
            C_FRD:
            begin
                ctl_next = C_FEMIT;
            end
            C_FEMIT:
            begin
                if (out_space)
                begin
                    load            = 1'b1;
                    res.send_valid  = fire_ack;
                    res.send_byte   = fire_ack ? ACK_BYTE : 8'h00;
                    res.write_valid = 1'b1;
                    res.mem_addr    = addr_out(addr_reg + 16'(fidx_reg));
                    res.mem_data    = ram_rdata;
                    res.last        = fire_ack;
                    if (fire_ack)
                    begin
                        ctl_next = C_IDLE;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + IDX_W'(1);
                        ctl_next  = C_FRD;
                    end
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase

        res.busy_res = busy_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            ctl_reg         <= C_IDLE;
            cmd_reg         <= CMD_WBYTE;
            addr_reg        <= '0;
            start_reg       <= '0;
            start_valid_reg <= 1'b0;
            cursor_reg      <= '0;
            fill_reg        <= '0;
            esc_reg         <= 1'b0;
            busy_reg        <= 1'b0;
            fidx_reg        <= '0;
            flast_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            ctl_reg         <= ctl_next;
            cmd_reg         <= cmd_next;
            addr_reg        <= addr_next;
            start_reg       <= start_next;
            start_valid_reg <= start_valid_next;
            cursor_reg      <= cursor_next;
            fill_reg        <= fill_next;
            esc_reg         <= esc_next;
            busy_reg        <= busy_next;
            fidx_reg        <= fidx_next;
            flast_reg       <= flast_next;
        end
    end

    // page buffer
    ecb_page_ram #(
        .DEPTH (PAGE_BYTES),
        .IDX_W (IDX_W)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (s_tdata),
        .raddr (fidx_reg),
        .rdata (ram_rdata)
    );

    // result output stage
    ecb_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // a flush runs only after the stream has ended
    a_flush_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_FRD || ctl_reg == C_FEMIT) |-> !busy_reg)
        else $error("flush while busy");

    // flush index never passes the last filled entry
    a_flush_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_FRD || ctl_reg == C_FEMIT) |-> fidx_reg <= flast_reg)
        else $error("flush index out of range");

    // page writes only while a write stream collects data
    a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (phase_reg == PH_DATA && cmd_reg == CMD_WSTREAM &&
                    fill_reg < FILL_W'(PAGE_BYTES)))
        else $error("page write outside a write stream");

    // fill count stays within the page
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(PAGE_BYTES))
        else $error("fill count overflow");

    // a pending read keeps the bridge busy
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READ || phase_reg == PH_STREAM) |-> busy_reg)
        else $error("read pending while not busy");
`endif

endmodule

// File: tb/bridge_checker.sv
// checker for the serial command bridge: predicts result beats and compares them
module bridge_checker
    import ecb_pkg::*;
#(
    parameter int PAGE_BYTES = 64,
    parameter int ADDR_WIDTH = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // value
    input  logic               s_tuser,   // operation
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // send_valid, send_byte, write_valid,
                                          // read_valid, mem_addr, mem_data, busy_res
    input  logic               m_tlast,
    output int                 error_count,
    output int                 beats_pending,
    output int                 host_beats,
    output int                 mem_beats,
    output int                 write_reqs,
    output int                 read_reqs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_ADDR_HI = 6'b000010,
        PH_ADDR_LO = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_READ    = 6'b010000,
        PH_STREAM  = 6'b100000
    } phase_t;

    localparam logic [15:0] ADDR_MASK = 16'((1 << ADDR_WIDTH) - 1);

    // predicted bridge state
    phase_t      phase;
    cmd_t        command;
    logic [15:0] address;
    logic [15:0] start_address;
    logic [15:0] read_cursor;
    logic        start_valid;
    logic        escape_pending;
    logic        busy;
    logic [7:0]  page_buf [PAGE_BYTES];
    int          fill_count;

    res_t        result_q[$];   // expected result beats, oldest first
    res_t        step_q[$];     // beats caused by the input being predicted

    task automatic add_beat(input logic sv, input logic [7:0] sb, input logic wv,
                            input logic rv, input logic [15:0] addr,
                            input logic [7:0] data);
        res_t r;
        r             = '0;
        r.send_valid  = sv;
        r.send_byte   = sb;
        r.write_valid = wv;
        r.read_valid  = rv;
        r.mem_addr    = MEM_ADDR_W'(addr & ADDR_MASK);
        r.mem_data    = data;
        step_q.push_back(r);
    endtask

    task automatic end_command();
        phase = PH_IDLE;
        busy  = 1'b0;
    endtask

    // work out the result beats of one accepted input beat
    task automatic predict_bridge(input logic op, input logic [7:0] v);
        logic stored;
        step_q.delete();
        stored = 1'b0;
        if (op == KIND_MEM)
        begin
            // memory data only counts while a read is outstanding
            if (phase == PH_READ)
            begin
                add_beat(1'b1, v, 1'b0, 1'b0, 16'h0, 8'h0);
                end_command();
            end
            else if (phase == PH_STREAM)
            begin
                add_beat(1'b1, v, 1'b0, 1'b0, 16'h0, 8'h0);
                if (read_cursor == address)
                begin
                    start_valid = 1'b0;
                    end_command();
                end
                else
                begin
                    read_cursor = read_cursor + 16'd1;
                    add_beat(1'b0, 8'h0, 1'b0, 1'b1, read_cursor, 8'h0);
                end
            end
        end
        else
        begin
            case (phase)
                PH_IDLE:
                begin
                    if (v >= OP_WBYTE && v <= OP_RSTREAM)
                    begin
                        case (v)
                            OP_WBYTE:   command = CMD_WBYTE;
                            OP_WSTREAM: command = CMD_WSTREAM;
                            OP_RBYTE:   command = CMD_RBYTE;
                            default:    command = CMD_RSTREAM;
                        endcase
                        phase = PH_ADDR_HI;
                        busy  = 1'b1;
                    end
                    else if (v == OP_HANDSHAKE || v == OP_ESCAPE)
                        add_beat(1'b1, ACK_BYTE, 1'b0, 1'b0, 16'h0, 8'h0);
                    else
                        add_beat(1'b1, NAK_BYTE, 1'b0, 1'b0, 16'h0, 8'h0);
                end
                PH_ADDR_HI:
                begin
                    address = {v, 8'h00};
                    phase   = PH_ADDR_LO;
                end
                PH_ADDR_LO:
                begin
                    address[7:0] = v;
                    case (command)
                        CMD_WBYTE, CMD_WSTREAM:
                        begin
                            fill_count     = 0;
                            escape_pending = 1'b0;
                            phase          = PH_DATA;
                        end
                        CMD_RBYTE:
                        begin
                            add_beat(1'b0, 8'h0, 1'b0, 1'b1, address, 8'h0);
                            phase = PH_READ;
                        end
                        default:
                        begin
                            // read stream: first pair is the start, second the end
                            if (!start_valid)
                            begin
                                start_address = address;
                                start_valid   = 1'b1;
                                phase         = PH_ADDR_HI;
                            end
                            else
                            begin
                                start_valid = 1'b0;
                                if (address < start_address)
                                    end_command();
                                else
                                begin
                                    read_cursor = start_address;
                                    add_beat(1'b0, 8'h0, 1'b0, 1'b1, read_cursor, 8'h0);
                                    phase = PH_STREAM;
                                end
                            end
                        end
                    endcase
                end
                PH_DATA:
                begin
                    if (command == CMD_WBYTE)
                    begin
                        add_beat(1'b1, ACK_BYTE, 1'b1, 1'b0, address, v);
                        end_command();
                    end
                    else if (command == CMD_WSTREAM)
                    begin
                        if (escape_pending)
                        begin
                            escape_pending = 1'b0;
                            if (v == OP_ESCAPE)
                                stored = 1'b1;
                            else
                            begin
                                // page flush, ack rides on the last write
                                for (int i = 0; i < fill_count; i++)
                                    add_beat(i == fill_count - 1,
                                             (i == fill_count - 1) ? ACK_BYTE : 8'h00,
                                             1'b1, 1'b0, address + 16'(i), page_buf[i]);
                                if (fill_count == 0)
                                    add_beat(1'b1, ACK_BYTE, 1'b0, 1'b0, 16'h0, 8'h0);
                                fill_count = 0;
                                end_command();
                            end
                        end
                        else if (v == OP_ESCAPE)
                            escape_pending = 1'b1;
                        else
                            stored = 1'b1;
                        // bytes past a full page are dropped
                        if (stored && fill_count < PAGE_BYTES)
                        begin
                            page_buf[fill_count] = v;
                            fill_count++;
                        end
                    end
                    else
                        end_command();
                end
                PH_READ, PH_STREAM: ;
                default:
                    end_command();
            endcase
        end

        // an input with no effect still yields one empty beat
        if (step_q.size() == 0)
            add_beat(1'b0, 8'h0, 1'b0, 1'b0, 16'h0, 8'h0);
        foreach (step_q[i])
        begin
            step_q[i].busy_res = busy;
            step_q[i].last     = (i == step_q.size() - 1);
            result_q.push_back(step_q[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // predict on each input beat, compare each result beat
    always @(posedge clk or negedge rst_n)
    begin
        res_t seen;
        res_t want;
        if (!rst_n)
        begin
            phase          = PH_IDLE;
            command        = CMD_WBYTE;
            address        = '0;
            start_address  = '0;
            read_cursor    = '0;
            start_valid    = 1'b0;
            escape_pending = 1'b0;
            busy           = 1'b0;
            fill_count     = 0;
            result_q.delete();
            error_count    = 0;
            beats_pending  = 0;
            host_beats     = 0;
            mem_beats      = 0;
            write_reqs     = 0;
            read_reqs      = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == KIND_MEM)
                    mem_beats++;
                else
                    host_beats++;
                predict_bridge(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                // tdata from bit 0 up: send_valid, send_byte, write_valid,
                // read_valid, mem_addr, mem_data, busy_res
                seen.send_valid  = m_tdata[0];
                seen.send_byte   = m_tdata[8:1];
                seen.write_valid = m_tdata[9];
                seen.read_valid  = m_tdata[10];
                seen.mem_addr    = m_tdata[25:11];
                seen.mem_data    = m_tdata[33:26];
                seen.busy_res    = m_tdata[34];
                seen.last        = m_tlast;
                if (result_q.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata 0x%0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("send_valid", 16'(want.send_valid), 16'(seen.send_valid));
                    check_field("send_byte", 16'(want.send_byte), 16'(seen.send_byte));
                    check_field("write_valid", 16'(want.write_valid),
                                16'(seen.write_valid));
                    check_field("read_valid", 16'(want.read_valid), 16'(seen.read_valid));
                    check_field("mem_addr", 16'(want.mem_addr), 16'(seen.mem_addr));
                    check_field("mem_data", 16'(want.mem_data), 16'(seen.mem_data));
                    check_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
                    check_field("last", 16'(want.last), 16'(seen.last));
                    if (want.write_valid)
                        write_reqs++;
                    if (want.read_valid)
                        read_reqs++;
                end
            end
            beats_pending = result_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// top of the serial command bridge testbench: reset, clock, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ecb_pkg::*;

    localparam int PAGE_BYTES   = 64;
    localparam int ADDR_WIDTH   = 15;
    localparam int ITEMS        = 470;
    localparam int TAIL_ITEMS   = 60;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 150;

    // no test mode in this block, so this byte must be refused
    localparam logic [7:0] OP_TEST = 8'hEE;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // value
    logic               s_tuser;    // operation
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // send_valid, send_byte, write_valid,
                                    // read_valid, mem_addr, mem_data, busy_res
    logic               m_tlast;

    int error_count;
    int beats_pending;
    int host_beats;
    int mem_beats;
    int write_reqs;
    int read_reqs;

    int items_sent   = 0;
    int idle_cycles  = 0;
    bit sender_calm  = 1'b0;
    bit quiet_tail   = 1'b0;

    always #10ns clk = ~clk;

    eeprom_serial_command_bridge #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bridge_checker #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .beats_pending (beats_pending),
        .host_beats    (host_beats),
        .mem_beats     (mem_beats),
        .write_reqs    (write_reqs),
        .read_reqs     (read_reqs)
    );

    // one input beat, with an optional gap in front of it
    task automatic send_beat(input logic op, input logic [7:0] val);
        int gap;
        if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (items_sent >= ITEMS - TAIL_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // host byte outside a pending read; stray memory data may precede it
    task automatic send_host(input logic [7:0] val);
        if ($urandom_range(0, 11) == 0)
            send_beat(KIND_MEM, 8'($urandom));
        send_beat(KIND_HOST, val);
    endtask

    // memory data for a pending read; stray host bytes may precede it
    task automatic send_mem(input logic [7:0] val);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) send_beat(KIND_HOST, 8'($urandom));
        send_beat(KIND_MEM, val);
    endtask

    task automatic send_addr(input logic [15:0] addr);
        send_host(addr[15:8]);
        send_host(addr[7:0]);
    endtask

    // mostly anywhere, sometimes near the top so that the address wraps
    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(16'hFFF0, 16'hFFFF));
        return 16'($urandom);
    endfunction

    // receiver: stall bursts, calm stretches, always ready at the end
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet_tail || calm_left > 0)
            begin
                m_tready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1:    stall_left = $urandom_range(1, 19);
                    2:       calm_left = $urandom_range(20, 80);
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          kind;
        int          n;
        logic [15:0] a;
        logic [15:0] e;
        logic [7:0]  b;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = KIND_HOST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // replies at idle: handshake, cancel, refused test byte, stray memory data
        send_beat(KIND_HOST, OP_HANDSHAKE);
        send_beat(KIND_HOST, OP_ESCAPE);
        send_beat(KIND_HOST, OP_TEST);
        send_beat(KIND_MEM, 8'h00);
        // single write at the top address
        send_beat(KIND_HOST, OP_WBYTE);
        send_beat(KIND_HOST, 8'hFF);
        send_beat(KIND_HOST, 8'hFF);
        send_beat(KIND_HOST, 8'h5A);
        // single read, a host byte ignored while the read is pending
        send_beat(KIND_HOST, OP_RBYTE);
        send_beat(KIND_HOST, 8'h00);
        send_beat(KIND_HOST, 8'h00);
        send_beat(KIND_HOST, OP_WBYTE);
        send_beat(KIND_MEM, 8'hFF);
        // read stream with the end below the start reads nothing
        send_beat(KIND_HOST, OP_RSTREAM);
        send_beat(KIND_HOST, 8'h00);
        send_beat(KIND_HOST, 8'h05);
        send_beat(KIND_HOST, 8'h00);
        send_beat(KIND_HOST, 8'h03);
        // write stream closed at once: the flush carries the ack alone
        send_beat(KIND_HOST, OP_WSTREAM);
        send_beat(KIND_HOST, 8'h80);
        send_beat(KIND_HOST, 8'h00);
        send_beat(KIND_HOST, OP_ESCAPE);
        send_beat(KIND_HOST, 8'h41);

        // random commands with random content
        while (items_sent < ITEMS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                send_host(OP_WBYTE);
                send_addr(pick_addr());
                send_host(8'($urandom));
            end
            else if (kind < 45)
            begin
                // page stream, literal escapes doubled, now and then past a full page
                send_host(OP_WSTREAM);
                send_addr(pick_addr());
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
                                                 : $urandom_range(0, 12);
                repeat (n)
                begin
                    b = ($urandom_range(0, 5) == 0) ? OP_ESCAPE : 8'($urandom);
                    if (b == OP_ESCAPE)
                        send_host(OP_ESCAPE);
                    send_host(b);
                end
                send_host(OP_ESCAPE);
                do b = 8'($urandom); while (b == OP_ESCAPE);
                send_host(b);
            end
            else if (kind < 60)
            begin
                send_host(OP_RBYTE);
                send_addr(pick_addr());
                send_mem(8'($urandom));
            end
            else if (kind < 80)
            begin
                // read stream, n bytes long, or empty with the end below the start
                send_host(OP_RSTREAM);
                n = $urandom_range(0, 9);
                if (n == 0)
                begin
                    a = 16'($urandom_range(1, 16'hFFFF));
                    e = 16'($urandom_range(0, a - 1));
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        a = 16'hFFFF - 16'(n - 1);
                    else
                        a = 16'($urandom_range(0, 16'hFFFF - (n - 1)));
                    e = a + 16'(n - 1);
                end
                send_addr(a);
                send_addr(e);
                repeat (n) send_mem(8'($urandom));
            end
            else if (kind < 90)
            begin
                // non-command host byte at idle
                if ($urandom_range(0, 2) == 0)
                    b = ($urandom_range(0, 1) == 0) ? OP_HANDSHAKE : OP_ESCAPE;
                else
                    do b = 8'($urandom); while (b >= OP_WBYTE && b <= OP_RSTREAM);
                send_beat(KIND_HOST, b);
            end
            else
                send_beat(KIND_MEM, 8'($urandom));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (beats_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d host bytes and %0d memory data bytes",
                 host_beats, mem_beats);
        $display("checked %0d memory writes and %0d read requests", write_reqs, read_reqs);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
